// File: hdl/order_statistic_multiset_assert.svh
// ----------------------------------------------------------------------------
// Order statistic multiset assertion macros
// Shared concurrent assertion forms for the order statistic multiset block.
// ----------------------------------------------------------------------------
`ifndef ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hdl/osm_pkg.sv
// ----------------------------------------------------------------------------
// Order statistic multiset package
// Sizes, request codes and sequencer states for the order statistic multiset.
// ----------------------------------------------------------------------------
`default_nettype none

package osm_pkg;

  localparam int CAPACITY = 256;
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RANK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_KTH    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PRED   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SUCC   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_FETCH_RD,
    ST_FETCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_RESPOND
  } state_t;

endpackage

`default_nettype wire

// File: hdl/order_statistic_multiset.sv
// Rank, predecessor and successor queries run a binary search of the value memory
// with a read state and a compare state per probe; k-th reads its entry directly.
// Insert and delete add a read and a write state per entry moved up or down.
// One item is handled at a time; a result waits in the output register.
// Reset clears the count, the overflow flag and the sequencer; the value
// memory keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// Order statistic multiset
// Sorted store of signed values with insert, delete, rank, k-th, predecessor
// and successor requests, run by a sequencer around one compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module order_statistic_multiset (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [osm_pkg::MODE_W-1:0]       mode,
  input  wire logic signed [osm_pkg::DATA_W-1:0] operand,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [osm_pkg::DATA_W-1:0]     answer,
  output logic                                  status,
  output logic                                  overflow_seen
);

  import osm_pkg::*;

  state_t state, state_next;

  logic [MODE_W-1:0]        req_mode, req_mode_next;
  logic signed [DATA_W-1:0] req_x, req_x_next;
  logic [CNT_W-1:0]         lo, lo_next;
  logic [CNT_W-1:0]         hi, hi_next;
  logic [CNT_W-1:0]         idx, idx_next;
  logic [ADDR_W-1:0]        addr, addr_next;
  logic [CNT_W-1:0]         count, count_next;
  logic                     overflow_flag, overflow_flag_next;
  logic [DATA_W-1:0]        res_answer, res_answer_next;
  logic                     res_miss, res_miss_next;
  logic                     out_valid_next;
  logic signed [DATA_W-1:0] answer_next;
  logic                     status_next;
  logic                     overflow_seen_next;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        rd_data;

  logic [CNT_W:0]           mid_sum;
  logic [ADDR_W-1:0]        mid;
  logic                     rd_lt;
  logic                     rd_eq;
  logic                     go_right;
  logic                     accept;
  logic                     full;
  logic                     kth_miss;
  logic                     search_end;
  logic                     out_free;
  logic                     shift_more_up;
  logic                     shift_more_down;

  osm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_values (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign accept     = in_valid && in_ready;
  assign full       = count == CAP_CNT;
  assign kth_miss   = (operand < 32'sd1) || (operand > $signed(DATA_W'(count)));
  assign search_end = lo == hi;
  assign out_free   = !out_valid || out_ready;
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[ADDR_W:1];

  assign rd_lt    = $signed(rd_data) < req_x;
  assign rd_eq    = $signed(rd_data) == req_x;
  assign go_right = (req_mode == MODE_INSERT || req_mode == MODE_SUCC) ? (rd_lt || rd_eq)
                                                                      : rd_lt;

  assign shift_more_up   = (idx - CNT_W'(1)) > lo;
  assign shift_more_down = ({1'b0, idx} + (CNT_W + 1)'(2)) < {1'b0, count};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_INSERT) begin
            state_next = full ? ST_IDLE : ST_SRCH_RD;
          end else if (mode == MODE_KTH) begin
            state_next = kth_miss ? ST_RESPOND : ST_FETCH_RD;
          end else if (mode == MODE_DELETE || mode == MODE_RANK ||
                       mode == MODE_PRED || mode == MODE_SUCC) begin
            state_next = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD: begin
        if (!search_end) begin
          state_next = ST_SRCH_CMP;
        end else begin
          unique case (req_mode)
            MODE_INSERT: state_next = (count > lo) ? ST_SHIFT_RD : ST_PLACE;
            MODE_DELETE: state_next = (lo < count) ? ST_FETCH_RD : ST_IDLE;
            MODE_RANK:   state_next = ST_RESPOND;
            MODE_PRED:   state_next = (lo == '0) ? ST_RESPOND : ST_FETCH_RD;
            MODE_SUCC:   state_next = (lo >= count) ? ST_RESPOND : ST_FETCH_RD;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_SRCH_CMP:  state_next = ST_SRCH_RD;
      ST_FETCH_RD:  state_next = ST_FETCH_CMP;
      ST_FETCH_CMP: begin
        if (req_mode == MODE_DELETE) begin
          if (rd_eq && ({1'b0, lo} + (CNT_W + 1)'(1)) < {1'b0, count}) begin
            state_next = ST_SHIFT_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_RESPOND;
        end
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (req_mode == MODE_INSERT) begin
          state_next = shift_more_up ? ST_SHIFT_RD : ST_PLACE;
        end else begin
          state_next = shift_more_down ? ST_SHIFT_RD : ST_IDLE;
        end
      end
      ST_PLACE:   state_next = ST_IDLE;
      ST_RESPOND: state_next = out_free ? ST_IDLE : ST_RESPOND;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == ST_IDLE;
    ram_we    = 1'b0;
    ram_waddr = idx[ADDR_W-1:0];
    ram_wdata = rd_data;
    ram_raddr = mid;
    unique case (state)
      ST_FETCH_RD: ram_raddr = addr;
      ST_SHIFT_RD: begin
        if (req_mode == MODE_INSERT) begin
          ram_raddr = ADDR_W'(idx - CNT_W'(1));
        end else begin
          ram_raddr = ADDR_W'(idx + CNT_W'(1));
        end
      end
      ST_SHIFT_WR: ram_we = 1'b1;
      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = lo[ADDR_W-1:0];
        ram_wdata = req_x;
      end
      default: ram_raddr = mid;
    endcase
  end

  always_comb begin
    req_mode_next      = req_mode;
    req_x_next         = req_x;
    lo_next            = lo;
    hi_next            = hi;
    idx_next           = idx;
    addr_next          = addr;
    count_next         = count;
    overflow_flag_next = overflow_flag;
    res_answer_next    = res_answer;
    res_miss_next      = res_miss;
    out_valid_next     = out_valid && !out_ready;
    answer_next        = answer;
    status_next        = status;
    overflow_seen_next = overflow_seen;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          req_mode_next   = mode;
          req_x_next      = operand;
          lo_next         = '0;
          hi_next         = count;
          idx_next        = count;
          addr_next       = ADDR_W'(operand[ADDR_W-1:0] - ADDR_W'(1));
          res_answer_next = '0;
          res_miss_next   = 1'b1;
          if (mode == MODE_INSERT && full) begin
            overflow_flag_next = 1'b1;
          end
        end
      end
      ST_SRCH_RD: begin
        if (search_end) begin
          unique case (req_mode)
            MODE_RANK: begin
              res_answer_next = DATA_W'(lo) + DATA_W'(1);
              res_miss_next   = 1'b0;
            end
            MODE_PRED: addr_next = ADDR_W'(lo - CNT_W'(1));
            default:   addr_next = lo[ADDR_W-1:0];
          endcase
        end
      end
      ST_SRCH_CMP: begin
        if (go_right) begin
          lo_next = CNT_W'(mid) + CNT_W'(1);
        end else begin
          hi_next = CNT_W'(mid);
        end
      end
      ST_FETCH_CMP: begin
        if (req_mode == MODE_DELETE) begin
          idx_next = lo;
          if (rd_eq && ({1'b0, lo} + (CNT_W + 1)'(1)) >= {1'b0, count}) begin
            count_next = count - CNT_W'(1);
          end
        end else begin
          res_answer_next = rd_data;
          res_miss_next   = 1'b0;
        end
      end
      ST_SHIFT_WR: begin
        if (req_mode == MODE_INSERT) begin
          idx_next = idx - CNT_W'(1);
        end else begin
          idx_next = idx + CNT_W'(1);
          if (!shift_more_down) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      ST_PLACE: count_next = count + CNT_W'(1);
      ST_RESPOND: begin
        if (out_free) begin
          out_valid_next     = 1'b1;
          answer_next        = res_miss ? '0 : $signed(res_answer);
          status_next        = res_miss;
          overflow_seen_next = overflow_flag;
        end
      end
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_flag <= overflow_flag_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_mode      <= req_mode_next;
    req_x         <= req_x_next;
    lo            <= lo_next;
    hi            <= hi_next;
    idx           <= idx_next;
    addr          <= addr_next;
    res_answer    <= res_answer_next;
    res_miss      <= res_miss_next;
    answer        <= answer_next;
    status        <= status_next;
    overflow_seen <= overflow_seen_next;
  end

`include "order_statistic_multiset_assert.svh"

  `OSM_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_CNT)
  `OSM_ASSERT_NEXT(a_full_insert_flags, accept && mode == MODE_INSERT && full, overflow_flag)
  `OSM_ASSERT_NOW(a_search_order, state == ST_SRCH_CMP, lo < hi && hi <= count)
  `OSM_ASSERT_NEXT(a_count_step, 1'b1, count == $past(count) || count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1))
  `OSM_ASSERT_NOW(a_result_source, $rose(out_valid), $past(state) == ST_RESPOND)

endmodule

`default_nettype wire

// File: hdl/osm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
